FILE: hdl/iss_pkg.sv
// Shared types and constants for the indexed sequence store.
// Used by iss_ctrl, iss_datapath and indexed_sequence_store_top; depends on nothing.
package iss_pkg;

	localparam int CAPACITY_DEF = 64;
	localparam int DATA_W       = 32;
	localparam int POS_W        = 8;
	localparam int COUNT_W      = 7;

	typedef enum logic [3:0] {
		CMD_PUSH_BACK  = 4'd0,
		CMD_PUSH_FRONT = 4'd1,
		CMD_PUSH_AT    = 4'd2,
		CMD_POP_BACK   = 4'd3,
		CMD_POP_FRONT  = 4'd4,
		CMD_POP_AT     = 4'd5,
		CMD_READ_BACK  = 4'd6,
		CMD_READ_FRONT = 4'd7,
		CMD_READ_AT    = 4'd8,
		CMD_CONTAINS   = 4'd9,
		CMD_CLEAR      = 4'd10
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t                     command;
		logic signed [POS_W-1:0]  position;
		logic signed [DATA_W-1:0] value;
	} item_t;

	typedef struct packed {
		status_t                  status;
		logic signed [DATA_W-1:0] read_value;
		logic                     found;
		logic [COUNT_W-1:0]       count;
	} result_t;

	// What the decoded word asks of the datapath
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_REMOVE,
		ACT_READ,
		ACT_SCAN,
		ACT_CLEAR
	} act_t;

	// Datapath operation for the current cycle
	typedef enum logic [3:0] {
		OP_IDLE,
		OP_LOAD,
		OP_DECODE,
		OP_INS_STEP,
		OP_STORE,
		OP_REM_STEP,
		OP_READ,
		OP_SCAN_STEP,
		OP_REPORT
	} op_t;

	typedef struct packed {
		act_t act;
		logic ins_end;
		logic walk_end;
		logic out_free;
	} sts_t;

endpackage

FILE: hdl/iss_ctrl.sv
// Controller state machine for the indexed sequence store.
// Depends on iss_pkg; drives the datapath operation from its status.
module iss_ctrl (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cmd_valid,
	output logic         cmd_stall,
	input  iss_pkg::sts_t sts,
	output iss_pkg::op_t  op
);
	import iss_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_INSERT,
		S_STORE,
		S_REMOVE,
		S_READ,
		S_SCAN,
		S_REPORT
	} state_t;

	state_t state_q;
	state_t state_d;

	assign cmd_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		op      = OP_IDLE;
		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					op      = OP_LOAD;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				op = OP_DECODE;
				case (sts.act)
					ACT_INSERT: state_d = S_INSERT;
					ACT_REMOVE: state_d = S_REMOVE;
					ACT_READ:   state_d = S_READ;
					ACT_SCAN:   state_d = S_SCAN;
					default:    state_d = S_REPORT;
				endcase
			end
			S_INSERT: begin
				op = OP_INS_STEP;
				if (sts.ins_end) begin
					state_d = S_STORE;
				end
			end
			S_STORE: begin
				op      = OP_STORE;
				state_d = S_REPORT;
			end
			S_REMOVE: begin
				op = OP_REM_STEP;
				if (sts.walk_end) begin
					state_d = S_REPORT;
				end
			end
			S_READ: begin
				op      = OP_READ;
				state_d = S_REPORT;
			end
			S_SCAN: begin
				op = OP_SCAN_STEP;
				if (sts.walk_end) begin
					state_d = S_REPORT;
				end
			end
			S_REPORT: begin
				// hold until the result register can take the word
				if (sts.out_free) begin
					op      = OP_REPORT;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

FILE: hdl/iss_datapath.sv
// Datapath of the indexed sequence store: entry memory, occupancy, walk pointer,
// command decode and result register. Depends on iss_pkg; driven by iss_ctrl.
module iss_datapath #(
	parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  iss_pkg::op_t     op,
	input  iss_pkg::item_t   cmd_word,
	output iss_pkg::sts_t    sts,
	output logic             res_valid,
	input  logic             res_stall,
	output iss_pkg::result_t res_word
);
	import iss_pkg::*;

	localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int OCC_W  = $clog2(CAPACITY + 1);
	localparam int IW     = ((OCC_W > POS_W) ? OCC_W : POS_W) + 1;

	logic [DATA_W-1:0] mem [CAPACITY];
	logic [DATA_W-1:0] rd_q;

	item_t            item_q;
	logic [OCC_W-1:0] occ_q;
	logic [OCC_W-1:0] ptr_q;
	logic [OCC_W-1:0] idx_q;
	logic [ADDR_W-1:0] wa_q;
	logic             wpend_q;
	logic             cmp_pend_q;
	logic             found_q;
	act_t             act_q;
	status_t          st_q;
	result_t          out_q;
	logic             out_valid_q;

	logic signed [IW-1:0] pos_x;
	logic signed [IW-1:0] n_x;
	logic signed [IW-1:0] at_x;
	logic signed [IW-1:0] real_x;
	logic signed [IW-1:0] dec_idx;
	act_t                 dec_act;
	status_t              dec_st;

	logic [OCC_W-1:0]         ptr_m1;
	logic [OCC_W-1:0]         ptr_p1;
	logic [OCC_W-1:0]         occ_next;
	logic [OCC_W+COUNT_W-1:0] occ_wide;
	logic                     ins_end;
	logic                     walk_end;
	logic                     out_free;
	logic                     re;
	logic [ADDR_W-1:0]        raddr;
	logic                     we;
	logic [ADDR_W-1:0]        waddr;
	logic [DATA_W-1:0]        wdata;
	result_t                  res_d;

	// Decode the held word against the current occupancy
	always_comb begin
		pos_x   = IW'(item_q.position);
		n_x     = IW'(occ_q);
		real_x  = (pos_x < 0) ? (pos_x + n_x) : pos_x;
		at_x    = pos_x;
		dec_act = ACT_NONE;
		dec_st  = ST_OK;
		dec_idx = '0;
		case (item_q.command)
			CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_PUSH_AT: begin
				if (item_q.command == CMD_PUSH_BACK) begin
					at_x = n_x;
				end else if (item_q.command == CMD_PUSH_FRONT) begin
					at_x = '0;
				end
				if (at_x < 0 || at_x > n_x) begin
					dec_st = ST_RANGE;
				end else if (occ_q >= OCC_W'(CAPACITY)) begin
					dec_st = ST_FULL;
				end else begin
					dec_act = ACT_INSERT;
					dec_idx = at_x;
				end
			end
			CMD_POP_BACK, CMD_POP_FRONT: begin
				if (occ_q == '0) begin
					dec_st = ST_EMPTY;
				end else begin
					dec_act = ACT_REMOVE;
					dec_idx = (item_q.command == CMD_POP_BACK) ? (n_x - IW'(1)) : '0;
				end
			end
			CMD_POP_AT: begin
				if (pos_x < 0 || pos_x >= n_x) begin
					dec_st = ST_RANGE;
				end else begin
					dec_act = ACT_REMOVE;
					dec_idx = pos_x;
				end
			end
			CMD_READ_BACK, CMD_READ_FRONT: begin
				if (occ_q == '0) begin
					dec_st = ST_EMPTY;
				end else begin
					dec_act = ACT_READ;
					dec_idx = (item_q.command == CMD_READ_BACK) ? (n_x - IW'(1)) : '0;
				end
			end
			CMD_READ_AT: begin
				if (real_x < 0 || real_x >= n_x) begin
					dec_st = ST_RANGE;
				end else begin
					dec_act = ACT_READ;
					dec_idx = real_x;
				end
			end
			CMD_CONTAINS: dec_act = ACT_SCAN;
			CMD_CLEAR:    dec_act = ACT_CLEAR;
			default:      dec_act = ACT_NONE;
		endcase
	end

	assign ptr_m1   = ptr_q - OCC_W'(1);
	assign ptr_p1   = ptr_q + OCC_W'(1);
	assign ins_end  = (ptr_q == idx_q);
	assign walk_end = (ptr_q == occ_q);
	assign out_free = !out_valid_q || !res_stall;

	assign sts.act      = dec_act;
	assign sts.ins_end  = ins_end;
	assign sts.walk_end = walk_end;
	assign sts.out_free = out_free;

	// Memory port selection
	always_comb begin
		re    = 1'b0;
		raddr = ptr_q[ADDR_W-1:0];
		case (op)
			OP_INS_STEP: begin
				re    = !ins_end;
				raddr = ptr_m1[ADDR_W-1:0];
			end
			OP_REM_STEP, OP_SCAN_STEP: begin
				re    = !walk_end;
				raddr = ptr_q[ADDR_W-1:0];
			end
			OP_READ: begin
				re    = 1'b1;
				raddr = idx_q[ADDR_W-1:0];
			end
			default: begin
				re = 1'b0;
			end
		endcase
	end

	assign we    = wpend_q || (op == OP_STORE);
	assign waddr = (op == OP_STORE) ? idx_q[ADDR_W-1:0] : wa_q;
	assign wdata = (op == OP_STORE) ? item_q.value : rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rd_q <= mem[raddr];
		end
	end

	always_comb begin
		case (act_q)
			ACT_INSERT: occ_next = occ_q + OCC_W'(1);
			ACT_REMOVE: occ_next = occ_q - OCC_W'(1);
			ACT_CLEAR:  occ_next = '0;
			default:    occ_next = occ_q;
		endcase
	end

	assign occ_wide = {COUNT_W'(0), occ_next};

	always_comb begin
		res_d.status     = st_q;
		res_d.read_value = (act_q == ACT_READ) ? rd_q : '0;
		res_d.found      = found_q;
		res_d.count      = occ_wide[COUNT_W-1:0];
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (op == OP_LOAD) begin
			item_q <= cmd_word;
		end
		if (op == OP_INS_STEP) begin
			wa_q <= ptr_q[ADDR_W-1:0];
		end else if (op == OP_REM_STEP) begin
			wa_q <= ptr_m1[ADDR_W-1:0];
		end
		if (op == OP_REPORT) begin
			out_q <= res_d;
		end
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q       <= '0;
			ptr_q       <= '0;
			idx_q       <= '0;
			wpend_q     <= 1'b0;
			cmp_pend_q  <= 1'b0;
			found_q     <= 1'b0;
			act_q       <= ACT_NONE;
			st_q        <= ST_OK;
			out_valid_q <= 1'b0;
		end else begin
			wpend_q    <= 1'b0;
			cmp_pend_q <= 1'b0;
			if (cmp_pend_q && (rd_q == item_q.value)) begin
				found_q <= 1'b1;
			end
			case (op)
				OP_DECODE: begin
					act_q   <= dec_act;
					st_q    <= dec_st;
					idx_q   <= dec_idx[OCC_W-1:0];
					found_q <= 1'b0;
					case (dec_act)
						ACT_INSERT: ptr_q <= occ_q;
						ACT_REMOVE: ptr_q <= dec_idx[OCC_W-1:0] + OCC_W'(1);
						default:    ptr_q <= '0;
					endcase
				end
				OP_INS_STEP: begin
					// move one entry up, walking down towards the insert point
					if (!ins_end) begin
						ptr_q   <= ptr_m1;
						wpend_q <= 1'b1;
					end
				end
				OP_REM_STEP: begin
					// move one entry down, walking up towards the back
					if (!walk_end) begin
						ptr_q   <= ptr_p1;
						wpend_q <= 1'b1;
					end
				end
				OP_SCAN_STEP: begin
					if (!walk_end) begin
						ptr_q      <= ptr_p1;
						cmp_pend_q <= 1'b1;
					end
				end
				default: begin
					ptr_q <= ptr_q;
				end
			endcase
			if (op == OP_REPORT) begin
				occ_q       <= occ_next;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign res_valid = out_valid_q;
	assign res_word  = out_q;

endmodule

FILE: hdl/indexed_sequence_store_top.sv
// Indexed sequence store: one word in, one result word out, n entries stored.
// An insert at k moves entries k to n-1 up; a remove at k moves the entries above k down;
// contains compares all n entries; errors, clear and reads move no entries. The entry memory,
// with one read and one write per cycle, sets the pace: one entry is moved or compared per cycle.
// The result is returned in a registered output.
// The next word is taken while it waits. Reset clears count and control; entries are not cleared.
module indexed_sequence_store_top #(
	parameter int CAPACITY = iss_pkg::CAPACITY_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	output logic             cmd_stall,
	input  iss_pkg::item_t   cmd_word,
	output logic             res_valid,
	input  logic             res_stall,
	output iss_pkg::result_t res_word
);
	import iss_pkg::*;

	op_t  op;
	sts_t sts;

	iss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.sts       (sts),
		.op        (op)
	);

	iss_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.cmd_word  (cmd_word),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_word  (res_word)
	);

endmodule

FILE: test/tb_indexed_sequence_store_top.sv
`timescale 1ns / 100ps
// Self-checking bench for indexed_sequence_store_top: directed and random command words.
// A mirror of the stored sequence predicts every result word. Depends on iss_pkg and the RTL.
module tb_indexed_sequence_store_top;
	import iss_pkg::*;

	localparam int CAPACITY       = CAPACITY_DEF;
	localparam int CMD_MAX_CODE   = (1 << $bits(cmd_t)) - 1;
	localparam int HOLD_CYCLES    = 200;
	localparam int DRAIN_CYCLES   = 100;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASES         = 4;
	localparam int SEND_IDLE_PCT[PHASES]  = '{0, 50, 0, 31};
	localparam int RECV_STALL_PCT[PHASES] = '{0, 0, 50, 31};

	// Mirror of the ordered store and the result words still owed by the block
	class sequence_mirror;
		logic signed [DATA_W-1:0] stored[$];
		result_t owed[$];
		int unsigned mismatches;

		function void note_command(item_t word);
			result_t r;
			int n, pos, at;
			n = stored.size();
			pos = $signed(word.position);
			r = '0;
			r.status = ST_OK;
			case (word.command)
				CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_PUSH_AT: begin
					at = (word.command == CMD_PUSH_BACK) ? n :
						(word.command == CMD_PUSH_FRONT) ? 0 : pos;
					// index check comes ahead of the full check
					if (at < 0 || at > n)
						r.status = ST_RANGE;
					else if (n >= CAPACITY)
						r.status = ST_FULL;
					else
						stored.insert(at, word.value);
				end
				CMD_POP_BACK, CMD_POP_FRONT: begin
					if (n == 0)
						r.status = ST_EMPTY;
					else if (word.command == CMD_POP_BACK)
						stored.delete(n - 1);
					else
						stored.delete(0);
				end
				CMD_POP_AT: begin
					if (pos < 0 || pos >= n)
						r.status = ST_RANGE;
					else
						stored.delete(pos);
				end
				CMD_READ_BACK, CMD_READ_FRONT: begin
					if (n == 0)
						r.status = ST_EMPTY;
					else
						r.read_value = (word.command == CMD_READ_BACK) ? stored[n - 1] : stored[0];
				end
				CMD_READ_AT: begin
					at = (pos < 0) ? n + pos : pos;
					if (at < 0 || at >= n)
						r.status = ST_RANGE;
					else
						r.read_value = stored[at];
				end
				CMD_CONTAINS: begin
					foreach (stored[i])
						if (stored[i] == word.value)
							r.found = 1'b1;
				end
				CMD_CLEAR: begin
					stored.delete();
				end
				default: begin
				end
			endcase
			r.count = COUNT_W'(stored.size());
			owed.insert(owed.size(), r);
		endfunction

		function void check_result(result_t got);
			result_t want;
			if (owed.size() == 0) begin
				$error("result word %h arrived with nothing outstanding", got);
				mismatches++;
				return;
			end
			want = owed[0];
			owed.delete(0);
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.read_value !== want.read_value) begin
				$error("read_value: expected %0d, got %0d", want.read_value, got.read_value);
				mismatches++;
			end
			if (got.found !== want.found) begin
				$error("found: expected %0d, got %0d", want.found, got.found);
				mismatches++;
			end
			if (got.count !== want.count) begin
				$error("count: expected %0d, got %0d", want.count, got.count);
				mismatches++;
			end
		endfunction
	endclass

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    cmd_valid = 1'b0;
	logic    cmd_stall;
	item_t   cmd_word = '0;
	logic    res_valid;
	logic    res_stall = 1'b0;
	result_t res_word;

	sequence_mirror mirror = new();

	int send_idle_pct = 0;
	int stall_pct = 0;
	int hold_asked = 0;
	int hold_seen = 0;
	int hold_left = 0;

	indexed_sequence_store_top #(
		.CAPACITY(CAPACITY)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd_word(cmd_word),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_word(res_word)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	// Receiver: check each accepted result word, then choose next cycle's stall
	always @(posedge clk) begin
		if (res_valid && !res_stall)
			mirror.check_result(res_word);
		if (hold_asked != hold_seen) begin
			hold_seen = hold_asked;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left--;
		end else begin
			res_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall))
				quiet = 0;
			else
				quiet++;
		end
		$display("FAILURE");
		$finish;
	end

	// Offer one command word, holding it until the block takes it
	task automatic offer(input item_t word);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd_valid <= 1'b1;
		cmd_word <= word;
		do @(posedge clk); while (cmd_stall);
		mirror.note_command(word);
	endtask

	task automatic offer_fields(input cmd_t command, input int position, input logic [31:0] value);
		item_t word;
		word.command = command;
		word.position = POS_W'(position);
		word.value = value;
		offer(word);
	endtask

	// Drop the valid and wait until every owed result word has come back
	task automatic pause_until_drained();
		cmd_valid <= 1'b0;
		do @(posedge clk); while (mirror.owed.size() != 0);
	endtask

	// Favour stored values and extremes so that searches hit often
	function automatic logic [DATA_W-1:0] pick_value();
		int n;
		n = mirror.stored.size();
		case ($urandom_range(0, 3))
			0: return (n > 0) ? mirror.stored[$urandom_range(0, n - 1)] : $urandom;
			1: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hffff_ffff;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	function automatic item_t fill_item();
		item_t word;
		int n;
		n = mirror.stored.size();
		word.value = pick_value();
		word.position = POS_W'($urandom);
		case ($urandom_range(0, 2))
			0: word.command = CMD_PUSH_BACK;
			1: word.command = CMD_PUSH_FRONT;
			default: begin
				word.command = CMD_PUSH_AT;
				word.position = POS_W'($urandom_range(0, n));
			end
		endcase
		return word;
	endfunction

	function automatic item_t mixed_item();
		item_t word;
		int n, pick;
		n = mirror.stored.size();
		pick = $urandom_range(0, 99);
		word.value = pick_value();
		word.position = POS_W'($urandom);
		// mostly legal indexes, the rest left as random noise
		if (pick < 14) begin
			word.command = CMD_PUSH_BACK;
		end else if (pick < 26) begin
			word.command = CMD_PUSH_FRONT;
		end else if (pick < 40) begin
			word.command = CMD_PUSH_AT;
			if ($urandom_range(0, 9) != 0)
				word.position = POS_W'($urandom_range(0, n));
		end else if (pick < 47) begin
			word.command = CMD_POP_BACK;
		end else if (pick < 53) begin
			word.command = CMD_POP_FRONT;
		end else if (pick < 62) begin
			word.command = CMD_POP_AT;
			if (n > 0 && $urandom_range(0, 9) != 0)
				word.position = POS_W'($urandom_range(0, n - 1));
		end else if (pick < 67) begin
			word.command = CMD_READ_BACK;
		end else if (pick < 71) begin
			word.command = CMD_READ_FRONT;
		end else if (pick < 83) begin
			word.command = CMD_READ_AT;
			if (n > 0 && $urandom_range(0, 9) != 0)
				word.position = POS_W'(int'($urandom_range(0, 2 * n - 1)) - n);
		end else if (pick < 96) begin
			word.command = CMD_CONTAINS;
		end else if (pick < 98) begin
			word.command = CMD_CLEAR;
		end else begin
			word.command = cmd_t'(4'($urandom_range(CMD_CLEAR + 1, CMD_MAX_CODE)));
		end
		return word;
	endfunction

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// empty store
		offer_fields(CMD_READ_BACK, 0, 32'h1);
		offer_fields(CMD_READ_FRONT, 0, 32'h2);
		offer_fields(CMD_POP_BACK, 0, 32'h3);
		offer_fields(CMD_POP_FRONT, 0, 32'h4);
		offer_fields(CMD_POP_AT, 0, 32'h5);
		offer_fields(CMD_READ_AT, -1, 32'h6);
		offer_fields(CMD_CONTAINS, 0, 32'h0);
		offer_fields(CMD_PUSH_AT, 1, 32'h7);
		offer_fields(CMD_PUSH_AT, -1, 32'h8);
		// build [min, 0, max, -1] by every kind of push
		offer_fields(CMD_PUSH_BACK, 0, 32'h7fff_ffff);
		offer_fields(CMD_PUSH_FRONT, 0, 32'h8000_0000);
		offer_fields(CMD_PUSH_AT, 1, 32'h0000_0000);
		offer_fields(CMD_PUSH_AT, 3, 32'hffff_ffff);
		offer_fields(CMD_READ_AT, -4, 32'h0);
		offer_fields(CMD_READ_AT, -5, 32'h0);
		offer_fields(CMD_READ_AT, 3, 32'h0);
		offer_fields(CMD_READ_AT, 4, 32'h0);
		offer_fields(CMD_READ_AT, -128, 32'h0);
		offer_fields(CMD_READ_AT, 127, 32'h0);
		offer_fields(CMD_CONTAINS, 0, 32'h8000_0000);
		offer_fields(CMD_POP_AT, 4, 32'h0);
		offer_fields(CMD_POP_AT, 1, 32'h0);
		offer_fields(CMD_READ_BACK, 0, 32'h0);
		offer_fields(CMD_READ_FRONT, 0, 32'h0);
		offer_fields(CMD_POP_BACK, 0, 32'h0);
		offer_fields(CMD_POP_FRONT, 0, 32'h0);
		offer_fields(cmd_t'(4'(CMD_CLEAR + 1)), -128, 32'hffff_ffff);
		offer_fields(cmd_t'(4'(CMD_MAX_CODE)), 127, 32'h0);
		offer_fields(CMD_CLEAR, 0, 32'h0);
		pause_until_drained();

		for (int ph = 0; ph < PHASES; ph++) begin
			send_idle_pct = SEND_IDLE_PCT[ph];
			stall_pct = RECV_STALL_PCT[ph];
			// long hold-off on the result side while words keep coming
			if (ph == 0)
				hold_asked <= hold_asked + 1;
			repeat (50) offer(mixed_item());
			while (mirror.stored.size() < CAPACITY)
				offer(fill_item());
			offer_fields(CMD_PUSH_BACK, 0, $urandom);
			offer_fields(CMD_PUSH_FRONT, 0, $urandom);
			offer_fields(CMD_PUSH_AT, $urandom_range(0, CAPACITY), $urandom);
			offer_fields(CMD_PUSH_AT, CAPACITY + 1, $urandom);
			offer_fields(CMD_PUSH_AT, -1, $urandom);
			repeat (25) offer(mixed_item());
			offer_fields(CMD_CLEAR, $urandom, $urandom);
			pause_until_drained();
		end

		cmd_valid <= 1'b0;
		do @(posedge clk); while (mirror.owed.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mirror.mismatches == 0 && mirror.owed.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: indexed_sequence_store_top.f
hdl/iss_pkg.sv
hdl/iss_ctrl.sv
hdl/iss_datapath.sv
hdl/indexed_sequence_store_top.sv
test/tb_indexed_sequence_store_top.sv
